[rtl/core/vsog_pkg.sv]
package vsog_pkg;

    localparam int MAX_RADIUS_DEF = 15;

    localparam int CNT_W    = 5;
    localparam int OFF_W    = 5;
    localparam int RADIUS_W = 4;
    localparam int SHAPE_W  = 3;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 24;

    localparam logic [SHAPE_W-1:0] SHAPE_SINGLE   = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_CUBE     = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_SPHERE   = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_CYLINDER = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_FLAT     = 3'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_SHAPE_MODE   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRUSH_RADIUS = 1'd1;

    typedef struct packed {
        logic [SHAPE_W-1:0]  shape_mode;
        logic [RADIUS_W-1:0] brush_radius;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] outer_count;
        logic [CNT_W-1:0] middle_count;
        logic [CNT_W-1:0] inner_count;
        logic             running;
    } scan_t;

    typedef struct packed {
        logic             active;
        logic             in_shape;
        logic [OFF_W-1:0] off_x;
        logic [OFF_W-1:0] off_y;
        logic [OFF_W-1:0] off_z;
        logic             last;
    } result_t;

endpackage

[rtl/core/voxel_shape_offset_generator.sv]
// channel | dir | handshake                 | payload
// s_*     | in  | s_tvalid / s_tready       | s_tdata: restart
// m_*     | out | m_tvalid / m_tready       | m_tdata: active, in_shape, off_x, off_y, off_z;
//         |     |                           | m_tlast: last
// cfg_*   | in  | cfg_valid / cfg_ready     | cfg_index: 0 shape_mode, 1 brush_radius; cfg_data
//
// one request per cycle while m_tready is high; stages: input register, then result register
// the cell is evaluated as the request moves from the input register to the result register
// reset clears the scan counters, running flag, configuration and both valid flags
// a stalled result holds the pipeline; with both stages full and m_tready low s_tready drops
// cfg_ready is always high
module voxel_shape_offset_generator #(
    parameter int MAX_RADIUS = vsog_pkg::MAX_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [vsog_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] restart, rest zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [vsog_pkg::M_TDATA_W-1:0]    m_tdata,   // [0] active, [1] in_shape,
                                                         // [6:2] off_x, [11:7] off_y,
                                                         // [16:12] off_z, rest zero
    output logic                              m_tlast,   // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vsog_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vsog_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import vsog_pkg::*;

    cfg_t    cfg_reg;
    scan_t   scan_reg;
    scan_t   scan_next;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    in_valid_reg;
    logic    in_restart_reg;
    logic    advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    vsog_step #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_step (
        .cfg       (cfg_reg),
        .scan      (scan_reg),
        .restart   (in_restart_reg),
        .result    (result),
        .scan_next (scan_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SHAPE_MODE:   cfg_reg.shape_mode   <= cfg_data[SHAPE_W-1:0];
                REG_BRUSH_RADIUS: cfg_reg.brush_radius <= cfg_data[RADIUS_W-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            scan_reg      <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                scan_reg      <= scan_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_restart_reg <= s_tdata[0];
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'b0000000, out_reg.off_z, out_reg.off_y, out_reg.off_x,
                       out_reg.in_shape, out_reg.active};

endmodule

[rtl/core/vsog_step.sv]
module vsog_step #(
    parameter int MAX_RADIUS = vsog_pkg::MAX_RADIUS_DEF
) (
    input  vsog_pkg::cfg_t    cfg,
    input  vsog_pkg::scan_t   scan,
    input  logic              restart,
    output vsog_pkg::result_t result,
    output vsog_pkg::scan_t   scan_next
);
    import vsog_pkg::*;

    localparam logic [6:0] MaxRadW = 7'(MAX_RADIUS);

    logic [RADIUS_W-1:0] r;
    logic [CNT_W-1:0]    span;
    logic [CNT_W-1:0]    so;
    logic [CNT_W-1:0]    sm;
    logic [CNT_W-1:0]    si;
    logic [SHAPE_W-1:0]  shape;
    scan_t               cur;
    logic signed [5:0]   a;
    logic signed [5:0]   b;
    logic signed [5:0]   c;
    logic signed [11:0]  aa;
    logic signed [11:0]  bb;
    logic signed [11:0]  cc;
    logic [9:0]          sum2;
    logic [9:0]          sum3;
    logic [7:0]          r2;
    logic                beyond;
    logic                fin;

    // radius saturation and span per shape
    always_comb
    begin
        if ({3'b000, cfg.brush_radius} > MaxRadW)
        begin
            r = RADIUS_W'(MAX_RADIUS);
        end
        else
        begin
            r = cfg.brush_radius;
        end
        span  = {r, 1'b0};
        shape = cfg.shape_mode;
        so    = span;
        sm    = span;
        si    = span;
        case (cfg.shape_mode)
            SHAPE_CUBE, SHAPE_SPHERE, SHAPE_CYLINDER:
            begin
                shape = cfg.shape_mode;
            end
            SHAPE_FLAT:
            begin
                si = '0;
            end
            default:
            begin
                shape = SHAPE_SINGLE;
                so    = '0;
                sm    = '0;
                si    = '0;
            end
        endcase
    end

    // restart zeroes the counters and starts the scan in the same step
    always_comb
    begin
        cur = scan;
        if (restart)
        begin
            cur.outer_count  = '0;
            cur.middle_count = '0;
            cur.inner_count  = '0;
            cur.running      = 1'b1;
        end
    end

    assign a = $signed({1'b0, cur.outer_count}) - $signed({2'b00, r});
    assign b = $signed({1'b0, cur.middle_count}) - $signed({2'b00, r});
    assign c = $signed({1'b0, cur.inner_count}) - $signed({2'b00, r});

    assign aa   = a * a;
    assign bb   = b * b;
    assign cc   = c * c;
    assign sum2 = 10'(aa[7:0]) + 10'(bb[7:0]);
    assign sum3 = sum2 + 10'(cc[7:0]);
    assign r2   = r * r;

    assign beyond = (cur.outer_count > so) || (cur.middle_count > sm) ||
                    (cur.inner_count > si);
    assign fin    = (cur.outer_count == so) && (cur.middle_count == sm) &&
                    (cur.inner_count == si);

    always_comb
    begin
        result    = '0;
        scan_next = cur;
        if (cur.running)
        begin
            if (beyond)
            begin
                scan_next.running = 1'b0;
            end
            else
            begin
                result.active = 1'b1;
                result.last   = fin;
                case (shape)
                    SHAPE_CUBE:
                    begin
                        result.off_x    = a[OFF_W-1:0];
                        result.off_y    = b[OFF_W-1:0];
                        result.off_z    = c[OFF_W-1:0];
                        result.in_shape = 1'b1;
                    end
                    SHAPE_SPHERE:
                    begin
                        result.off_x    = a[OFF_W-1:0];
                        result.off_y    = b[OFF_W-1:0];
                        result.off_z    = c[OFF_W-1:0];
                        result.in_shape = (sum3 <= 10'(r2));
                    end
                    SHAPE_CYLINDER:
                    begin
                        result.off_x    = a[OFF_W-1:0];
                        result.off_z    = b[OFF_W-1:0];
                        result.off_y    = c[OFF_W-1:0];
                        result.in_shape = (sum2 <= 10'(r2));
                    end
                    SHAPE_FLAT:
                    begin
                        result.off_x    = a[OFF_W-1:0];
                        result.off_z    = b[OFF_W-1:0];
                        result.off_y    = '0;
                        result.in_shape = 1'b1;
                    end
                    default:
                    begin
                        result.in_shape = 1'b1;
                    end
                endcase

                // advance the scan, innermost counter fastest
                if (fin)
                begin
                    scan_next.running = 1'b0;
                end
                else if (cur.inner_count < si)
                begin
                    scan_next.inner_count = cur.inner_count + 1'b1;
                end
                else
                begin
                    scan_next.inner_count = '0;
                    if (cur.middle_count < sm)
                    begin
                        scan_next.middle_count = cur.middle_count + 1'b1;
                    end
                    else
                    begin
                        scan_next.middle_count = '0;
                        scan_next.outer_count  = cur.outer_count + 1'b1;
                    end
                end
            end
        end
    end

endmodule

[tb/voxel_shape_offset_generator_chk.sv]
module voxel_shape_offset_generator_chk #(
    parameter int MAX_RADIUS = vsog_pkg::MAX_RADIUS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [vsog_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [vsog_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                              m_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [vsog_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [vsog_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                errors,
    output int                                pending
);
    import vsog_pkg::*;

    logic [SHAPE_W-1:0]  shape_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [CNT_W-1:0]    outer_idx;
    logic [CNT_W-1:0]    middle_idx;
    logic [CNT_W-1:0]    inner_idx;
    logic                scanning;
    result_t             cell_q[$];

    function automatic result_t next_cell(input logic restart);
        int           r;
        int           span_o;
        int           span_m;
        int           span_i;
        int           a;
        int           b;
        int           c;
        int           x;
        int           y;
        int           z;
        logic         in_cell;
        logic         done;
        logic [SHAPE_W-1:0] kind;
        result_t      res;
        r = (int'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
        span_o = 2 * r;
        span_m = span_o;
        span_i = span_o;
        kind = shape_reg;
        if (kind < SHAPE_CUBE || kind > SHAPE_FLAT)
        begin
            kind = SHAPE_SINGLE;
            span_o = 0;
            span_m = 0;
            span_i = 0;
        end
        else if (kind == SHAPE_FLAT)
            span_i = 0;
        if (restart)
        begin
            outer_idx = '0;
            middle_idx = '0;
            inner_idx = '0;
            scanning = 1'b1;
        end
        res = '0;
        if (!scanning)
            return res;
        // live config can leave the indices beyond the new span
        if (int'(outer_idx) > span_o || int'(middle_idx) > span_m || int'(inner_idx) > span_i)
        begin
            scanning = 1'b0;
            return res;
        end
        a = int'(outer_idx) - r;
        b = int'(middle_idx) - r;
        c = int'(inner_idx) - r;
        case (kind)
            SHAPE_CUBE:
            begin
                x = a; y = b; z = c;
                in_cell = 1'b1;
            end
            SHAPE_SPHERE:
            begin
                x = a; y = b; z = c;
                in_cell = (x * x + y * y + z * z) <= r * r;
            end
            SHAPE_CYLINDER:
            begin
                x = a; z = b; y = c;
                in_cell = (x * x + z * z) <= r * r;
            end
            SHAPE_FLAT:
            begin
                x = a; z = b; y = 0;
                in_cell = 1'b1;
            end
            default:
            begin
                x = 0; y = 0; z = 0;
                in_cell = 1'b1;
            end
        endcase
        done = int'(outer_idx) == span_o && int'(middle_idx) == span_m
            && int'(inner_idx) == span_i;
        res.active = 1'b1;
        res.in_shape = in_cell;
        res.off_x = x[OFF_W-1:0];
        res.off_y = y[OFF_W-1:0];
        res.off_z = z[OFF_W-1:0];
        res.last = done;
        if (done)
            scanning = 1'b0;
        else if (int'(inner_idx) < span_i)
            inner_idx = inner_idx + 1'b1;
        else
        begin
            inner_idx = '0;
            if (int'(middle_idx) < span_m)
                middle_idx = middle_idx + 1'b1;
            else
            begin
                middle_idx = '0;
                outer_idx = outer_idx + 1'b1;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            shape_reg = '0;
            radius_reg = '0;
            outer_idx = '0;
            middle_idx = '0;
            inner_idx = '0;
            scanning = 1'b0;
            cell_q.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SHAPE_MODE)
                    shape_reg = cfg_data[SHAPE_W-1:0];
                else if (cfg_index == REG_BRUSH_RADIUS)
                    radius_reg = cfg_data[RADIUS_W-1:0];
            end
            if (m_tvalid && m_tready)
            begin
                if (cell_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with no request waiting, tdata %h tlast %b",
                        $time, m_tdata, m_tlast);
                end
                else
                begin
                    want = cell_q.pop_front();
                    check_field("active", want.active, m_tdata[0]);
                    check_field("in_shape", want.in_shape, m_tdata[1]);
                    check_field("off_x", int'($signed(want.off_x)), int'($signed(m_tdata[6:2])));
                    check_field("off_y", int'($signed(want.off_y)), int'($signed(m_tdata[11:7])));
                    check_field("off_z", int'($signed(want.off_z)),
                        int'($signed(m_tdata[16:12])));
                    check_field("tdata padding", 0, int'(m_tdata[M_TDATA_W-1:17]));
                    check_field("last", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                cell_q.push_back(next_cell(s_tdata[0]));
            pending = cell_q.size();
        end
    end

endmodule

[tb/voxel_shape_offset_generator_tb.sv]
module voxel_shape_offset_generator_tb;
    import vsog_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic                    clk;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [S_TDATA_W-1:0]    s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [M_TDATA_W-1:0]    m_tdata;
    logic                    m_tlast;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int errors;
    int pending;
    int sent = 0;
    int tx_mode = 0;
    int rx_mode = 0;
    int hold_cnt = 0;
    int cycle_cnt = 0;

    voxel_shape_offset_generator dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    voxel_shape_offset_generator_chk chk (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // mode 0 means no idling
    function automatic int pick_gap(input int mode);
        int p;
        if (mode == 0)
            return 0;
        p = $urandom_range(99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic int scan_length(input logic [CFG_DATA_W-1:0] shape_data,
                                       input int radius);
        int n;
        logic [SHAPE_W-1:0] kind;
        n = 2 * radius + 1;
        kind = shape_data[SHAPE_W-1:0];
        if (kind == SHAPE_CUBE || kind == SHAPE_SPHERE || kind == SHAPE_CYLINDER)
            return n * n * n;
        if (kind == SHAPE_FLAT)
            return n * n;
        return 1;
    endfunction

    always @(posedge clk)
    begin
        int n;
        if (hold_cnt > 0)
        begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
        end
        else
        begin
            n = pick_gap(rx_mode);
            if (n > 0)
            begin
                m_tready <= 1'b0;
                hold_cnt <= n - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_req(input logic restart_bit);
        int gap;
        gap = pick_gap(tx_mode);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-1){1'b0}}, restart_bit};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    // hold off until every request has its result
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_brush(input logic [CFG_DATA_W-1:0] shape_data,
                              input logic [CFG_DATA_W-1:0] radius);
        cfg_valid <= 1'b1;
        cfg_index <= REG_SHAPE_MODE;
        cfg_data  <= shape_data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= REG_BRUSH_RADIUS;
        cfg_data  <= radius;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int p;
        int len;
        int n;
        int radius;
        logic [CFG_DATA_W-1:0] shape_data;
        logic fresh;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_SHAPE_MODE;
        cfg_data  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        rx_mode = 1;
        send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);
        settle();
        load_brush(4'hF, 4'd15);
        send_req(1'b1);
        send_req(1'b0);
        settle();
        load_brush({1'b0, SHAPE_FLAT}, 4'd0);
        send_req(1'b1);
        settle();
        load_brush({1'b0, SHAPE_CUBE}, 4'd0);
        send_req(1'b1);
        settle();
        load_brush({1'b0, SHAPE_SPHERE}, 4'd0);
        send_req(1'b1);
        settle();
        load_brush({1'b0, SHAPE_CYLINDER}, 4'd0);
        send_req(1'b1);
        settle();
        load_brush({1'b0, SHAPE_SPHERE}, 4'd15);
        send_req(1'b1);
        send_req(1'b0);
        send_req(1'b0);
        settle();
        // shrink the radius under a running scan
        load_brush({1'b0, SHAPE_SPHERE}, 4'd0);
        send_req(1'b0);
        send_req(1'b0);
        settle();
        load_brush({1'b0, SHAPE_CYLINDER}, 4'd1);
        send_req(1'b1);
        repeat (3) send_req(1'b0);
        settle();
        load_brush({1'b0, SHAPE_FLAT}, 4'd1);
        send_req(1'b0);
        settle();

        // one full flat scan at the largest radius
        tx_mode = 1;
        load_brush({1'b0, SHAPE_FLAT}, 4'd15);
        send_req(1'b1);
        repeat (scan_length({1'b0, SHAPE_FLAT}, 15) + 1) send_req(1'b0);
        settle();

        while (sent < 1900)
        begin
            tx_mode = $urandom_range(3);
            rx_mode = $urandom_range(3);
            p = $urandom_range(99);
            if (p < 85)
                shape_data = {1'b0, 3'($urandom_range(4, 1))};
            else
                shape_data = 4'($urandom_range(15));
            p = $urandom_range(99);
            if (p < 70)
                radius = $urandom_range(3);
            else if (p < 90)
                radius = $urandom_range(7, 4);
            else
                radius = $urandom_range(15, 8);
            load_brush(shape_data, 4'(radius));
            len = scan_length(shape_data, radius);
            p = $urandom_range(99);
            if (p < 70 && len <= 400)
                n = len - 1 + $urandom_range(4);
            else
                n = $urandom_range((len < 300) ? len : 300);
            // sometimes carry on the previous scan under the new brush
            fresh = $urandom_range(99) >= 15;
            if (fresh)
                send_req(1'b1);
            repeat (n)
            begin
                send_req($urandom_range(99) < 3);
                if ($urandom_range(999) < 5)
                    settle();
            end
            settle();
        end

        settle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/core/vsog_pkg.sv
rtl/core/vsog_step.sv
rtl/core/voxel_shape_offset_generator.sv
tb/voxel_shape_offset_generator_chk.sv
tb/voxel_shape_offset_generator_tb.sv
